// ----- rtl/rubsi_pkg.sv -----
// Shared constants for the ray/unit-box slab intersection block.
// No dependencies; imported by the top level and its checker.
`default_nettype none
package rubsi_pkg;
  localparam int WORD_W        = 32;  // width of every fixed-point field
  localparam int EPS_W         = 16;  // width of parallel_epsilon
  localparam int NUM_AXES      = 3;
  localparam int NUM_LANES     = 2 * NUM_AXES;  // entry and exit bound per axis
  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_TDATA_W    = 2 * NUM_AXES * WORD_W;
  localparam int OUT_FIELDS_W  = 1 + 2 * WORD_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};
endpackage
`default_nettype wire

// ----- rtl/ray_unit_box_slab_intersect.sv -----
// Top level of the ray/unit-box slab intersection pipeline.
// Depends on rubsi_pkg (widths, saturation limits, reset of the epsilon register).
`default_nettype none
// Slab test of one object-space ray against the box [-1,1]^3, signed fixed point
// with FRAC_BITS fraction bits. The block takes one ray beat per clock while the output
// is not stalled and returns one result beat per ray, in order, through these registers:
// one prepare stage, a 32-stage restoring divider array with six lanes (entry and
// exit bound of each axis), a saturate stage, a slab reduce stage and the output
// register. The whole pipe advances together; it holds only while a result waits
// at the output and the sink is not ready. parallel_epsilon is written through the
// cfg channel, which is always ready; write it only while the pipe is empty.
module ray_unit_box_slab_intersect
  import rubsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config: parallel_epsilon [15:0]
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [EPS_W-1:0]       cfg_data_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each, from bit 0)
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // tdata: hit [0], t_near [32:1], t_far [64:33], zero pad [71:65]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  localparam int DIV_STEPS = WORD_W;          // one quotient bit per stage
  localparam int NUM_W     = WORD_W + 2;      // +/-one - origin, signed
  localparam int P_OUT     = DIV_STEPS + 3;   // output register
  localparam logic signed [NUM_W-1:0] ONE_S = NUM_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] Q_NEG_LIM = {1'b1, {(WORD_W-1){1'b0}}};

  logic [EPS_W-1:0] eps_q;
  logic [P_OUT:0]   vld_q;
  logic             en;

  // divider lanes, stage k holds k quotient bits
  logic [WORD_W-1:0] rem_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic [WORD_W-1:0] low_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic [WORD_W-1:0] den_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic [WORD_W-1:0] quo_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic              neg_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic              ovf_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic              par_q [0:DIV_STEPS][0:NUM_LANES-1];
  logic signed [WORD_W-1:0] pval_q [0:DIV_STEPS][0:NUM_LANES-1];

  logic [WORD_W-1:0] rem_d [1:DIV_STEPS][0:NUM_LANES-1];
  logic [WORD_W-1:0] low_d [1:DIV_STEPS][0:NUM_LANES-1];
  logic [WORD_W-1:0] quo_d [1:DIV_STEPS][0:NUM_LANES-1];
  logic [WORD_W-1:0] rem0_d [0:NUM_LANES-1];
  logic [WORD_W-1:0] low0_d [0:NUM_LANES-1];
  logic [WORD_W-1:0] den_d [0:NUM_LANES-1];
  logic              neg_d [0:NUM_LANES-1];
  logic              ovf_d [0:NUM_LANES-1];
  logic              par_d [0:NUM_LANES-1];
  logic signed [WORD_W-1:0] pval_d [0:NUM_LANES-1];

  logic signed [WORD_W-1:0] bnd_d [0:NUM_LANES-1];
  logic signed [WORD_W-1:0] bnd_q [0:NUM_LANES-1];
  logic signed [WORD_W-1:0] near_d, far_d, near_q, far_q;
  logic signed [WORD_W-1:0] tn_q, tf_q;
  logic                     hit_q;

  assign en              = m_axis_tready_i || !vld_q[P_OUT];
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = vld_q[P_OUT];
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, tf_q, tn_q, hit_q};

  // Prepare: numerators, magnitudes, parallel test, overflow pre-check.
  always_comb begin
    logic signed [WORD_W-1:0] o, d;
    logic signed [NUM_W-1:0]  num, nneg, oext;
    logic [WORD_W-1:0]        mag, dmag;
    logic [2*WORD_W-1:0]      nfull;
    logic                     is_exit;
    for (int l = 0; l < NUM_LANES; l++) begin
      is_exit = l[0];
      o    = s_axis_tdata_i[(l/2)*WORD_W +: WORD_W];
      d    = s_axis_tdata_i[(NUM_AXES + l/2)*WORD_W +: WORD_W];
      oext = NUM_W'(o);
      num  = is_exit ? (ONE_S - oext) : (-ONE_S - oext);
      nneg = -num;
      mag  = num[NUM_W-1] ? nneg[WORD_W-1:0] : num[WORD_W-1:0];
      dmag = d[WORD_W-1] ? (WORD_W'(0) - d) : d;
      nfull = {{WORD_W{1'b0}}, mag} << FRAC_BITS;
      par_d[l] = (d == '0) || (dmag < WORD_W'(eps_q));
      neg_d[l] = num[NUM_W-1] ^ d[WORD_W-1];
      den_d[l] = dmag;
      ovf_d[l] = nfull[2*WORD_W-1:WORD_W] >= dmag;  // quotient needs > 32 bits
      rem0_d[l] = nfull[2*WORD_W-1:WORD_W];
      low0_d[l] = nfull[WORD_W-1:0];
      if (num > 0)       pval_d[l] = SAT_MAX;
      else if (num < 0)  pval_d[l] = SAT_MIN;
      else               pval_d[l] = is_exit ? SAT_MAX : SAT_MIN;
    end
  end

  // Restoring division, one bit per stage.
  always_comb begin
    logic [WORD_W:0] t;
    logic            ge;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        t  = {rem_q[k-1][l], low_q[k-1][l][WORD_W-1]};
        ge = t >= {1'b0, den_q[k-1][l]};
        rem_d[k][l] = ge ? WORD_W'(t - {1'b0, den_q[k-1][l]}) : t[WORD_W-1:0];
        low_d[k][l] = {low_q[k-1][l][WORD_W-2:0], 1'b0};
        quo_d[k][l] = {quo_q[k-1][l][WORD_W-2:0], ge};
      end
    end
  end

  // Sign, saturation and parallel override.
  always_comb begin
    logic [WORD_W-1:0] q;
    for (int l = 0; l < NUM_LANES; l++) begin
      q = quo_q[DIV_STEPS][l];
      if (par_q[DIV_STEPS][l])      bnd_d[l] = pval_q[DIV_STEPS][l];
      else if (ovf_q[DIV_STEPS][l]) bnd_d[l] = neg_q[DIV_STEPS][l] ? SAT_MIN : SAT_MAX;
      else if (neg_q[DIV_STEPS][l]) bnd_d[l] = (q > Q_NEG_LIM) ? SAT_MIN : -q;
      else                          bnd_d[l] = q[WORD_W-1] ? SAT_MAX : q;
    end
  end

  // Order each slab, then largest entry and smallest exit.
  always_comb begin
    logic signed [WORD_W-1:0] lo, hi;
    near_d = SAT_MIN;
    far_d  = SAT_MAX;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo = (bnd_q[2*a] > bnd_q[2*a+1]) ? bnd_q[2*a+1] : bnd_q[2*a];
      hi = (bnd_q[2*a] > bnd_q[2*a+1]) ? bnd_q[2*a]   : bnd_q[2*a+1];
      if (lo > near_d) near_d = lo;
      if (hi < far_d)  far_d  = hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) eps_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[P_OUT-1:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_q[0][l]  <= rem0_d[l];
        low_q[0][l]  <= low0_d[l];
        quo_q[0][l]  <= '0;
        den_q[0][l]  <= den_d[l];
        neg_q[0][l]  <= neg_d[l];
        ovf_q[0][l]  <= ovf_d[l];
        par_q[0][l]  <= par_d[l];
        pval_q[0][l] <= pval_d[l];
        for (int k = 1; k <= DIV_STEPS; k++) begin
          rem_q[k][l]  <= rem_d[k][l];
          low_q[k][l]  <= low_d[k][l];
          quo_q[k][l]  <= quo_d[k][l];
          den_q[k][l]  <= den_q[k-1][l];
          neg_q[k][l]  <= neg_q[k-1][l];
          ovf_q[k][l]  <= ovf_q[k-1][l];
          par_q[k][l]  <= par_q[k-1][l];
          pval_q[k][l] <= pval_q[k-1][l];
        end
        bnd_q[l] <= bnd_d[l];
      end
      near_q <= near_d;
      far_q  <= far_d;
      tn_q   <= near_q;
      tf_q   <= far_q;
      hit_q  <= near_q <= far_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rubsi_checker.sv -----
// Port-level checker for ray_unit_box_slab_intersect, bound to the top level.
// Depends on rubsi_pkg for the stream widths.
`default_nettype none
module rubsi_checker
  import rubsi_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready_o,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // hit flag agrees with the reported distances
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[0] ==
      ($signed(m_axis_tdata_o[WORD_W:1]) <= $signed(m_axis_tdata_o[2*WORD_W:WORD_W+1])))
    else $error("hit flag disagrees with t_near/t_far");

  // input side only holds back while a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (m_axis_tready_i || !m_axis_tvalid_o))
    else $error("input stalled without output back-pressure");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
    else $error("nonzero pad bits in result beat");

endmodule

bind ray_unit_box_slab_intersect rubsi_checker u_rubsi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

// ----- bench/tb_ray_unit_box_slab_intersect.sv -----
// Testbench for the ray/unit-box slab intersection pipeline.
// Depends on rubsi_pkg and ray_unit_box_slab_intersect; self-checking, no external files.
`default_nettype none
module tb_ray_unit_box_slab_intersect;
  import rubsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int PIPE_LAT = 40;        // pipe depth plus margin
  localparam int STALL_LIMIT = 20000;  // cycles with no beat before we give up

  typedef logic signed [WORD_W-1:0] fix_t;
  // packed from the top down, so hit lands in bit 0
  typedef struct packed {
    fix_t t_far;
    fix_t t_near;
    logic hit;
  } box_hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [EPS_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i = '0;  // origin_x,y,z, dir_x,y,z from bit 0
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;      // hit, t_near, t_far, zero pad

  ray_unit_box_slab_intersect dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state: shadow of the epsilon register
  logic [EPS_W-1:0] eps_shadow = EPS_RESET;
  box_hit_t hits_pending[$];
  int send_idle_pct = 0;   // chance in 100 that the sender holds tvalid low instead of sending
  int recv_stall_pct = 0;  // chance in 100 that the sink holds off
  int failures = 0;
  int quiet_cycles = 0;

  function automatic longint sat_word(longint v);
    if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return v;
  endfunction

  // one slab bound; zero numerator on a parallel axis opens the bound outward
  function automatic longint slab_limit(longint num, longint d, bit par, bit is_exit);
    if (!par) return sat_word((num <<< FRAC) / d);
    if (num > 0) return longint'(SAT_MAX);
    if (num < 0) return longint'(SAT_MIN);
    return is_exit ? longint'(SAT_MAX) : longint'(SAT_MIN);
  endfunction

  function automatic box_hit_t predict_box_hit(fix_t o[3], fix_t d[3]);
    longint one, near_t, far_t, lo, hi, tmp, dd, mag;
    bit par;
    box_hit_t r;
    one = longint'(1) <<< FRAC;
    near_t = longint'(SAT_MIN);
    far_t = longint'(SAT_MAX);
    for (int a = 0; a < 3; a++) begin
      dd = longint'(d[a]);
      mag = dd < 0 ? -dd : dd;
      par = (dd == 0) || (mag < longint'(eps_shadow));
      lo = slab_limit(-one - longint'(o[a]), dd, par, 1'b0);
      hi = slab_limit(one - longint'(o[a]), dd, par, 1'b1);
      if (lo > hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      if (lo > near_t) near_t = lo;
      if (hi < far_t) far_t = hi;
    end
    r.hit = near_t <= far_t;
    r.t_near = fix_t'(near_t);
    r.t_far = fix_t'(far_t);
    return r;
  endfunction

  // send one ray beat; tvalid drops only on idle cycles or when draining
  task automatic send_ray(fix_t o[3], fix_t d[3]);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i <= {d[2], d[1], d[0], o[2], o[1], o[0]};
    s_axis_tvalid_i <= 1'b1;
    hits_pending.push_back(predict_box_hit(o, d));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid_i <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  task automatic write_epsilon(logic [EPS_W-1:0] v);
    drain_pipe();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    eps_shadow = v;
  endtask

  // random word, biased toward the unit box scale and the extremes
  function automatic fix_t rand_word();
    case ($urandom_range(7))
      0: return fix_t'($urandom());
      1: return $urandom_range(1) ? SAT_MAX : SAT_MIN;
      2: return fix_t'($signed($urandom_range(65535)) - 32768);       // tiny
      3: return fix_t'(($urandom_range(1) ? 1 : -1) * 65536);          // on a face
      default: return fix_t'($signed($urandom_range(6 * 65536)) - 3 * 65536);
    endcase
  endfunction

  task automatic send_random_rays(int n);
    fix_t o[3], d[3];
    for (int i = 0; i < n; i++) begin
      foreach (o[a]) o[a] = rand_word();
      foreach (d[a]) d[a] = rand_word();
      send_ray(o, d);
    end
  endtask

  // extremes, parallel axes, origin on a face plane, zero direction, saturation
  task automatic test_directed();
    fix_t o[3], d[3];
    o = '{0, 0, 0};            d = '{65536, 0, 0};           send_ray(o, d);
    o = '{-3 * 65536, 0, 0};   d = '{65536, 0, 0};           send_ray(o, d);
    o = '{0, 5 * 65536, 0};    d = '{65536, 0, 0};           send_ray(o, d);  // miss
    o = '{65536, 0, 0};        d = '{0, 65536, 0};           send_ray(o, d);  // on face
    o = '{-65536, -65536, 0};  d = '{0, 0, 65536};           send_ray(o, d);
    o = '{0, 0, 0};            d = '{0, 0, 0};               send_ray(o, d);
    o = '{SAT_MAX, SAT_MIN, 0}; d = '{1, -1, 1};             send_ray(o, d);
    o = '{SAT_MIN, SAT_MAX, SAT_MAX}; d = '{SAT_MAX, SAT_MIN, -1}; send_ray(o, d);
    o = '{0, 0, 0};            d = '{SAT_MIN, SAT_MIN, SAT_MIN}; send_ray(o, d);
    o = '{-1, -1, -1};         d = '{-1, -1, -1};            send_ray(o, d);
    o = '{65535, -65535, 0};   d = '{32768, -32768, 1};      send_ray(o, d);
  endtask

  task automatic test_epsilon_sweep();
    fix_t o[3], d[3];
    logic [EPS_W-1:0] eps_vals[4] = '{16'd0, 16'd65535, 16'd300, 16'd1};
    foreach (eps_vals[k]) begin
      write_epsilon(eps_vals[k]);
      o = '{0, 0, 0}; d = '{0, 65535, 65534}; send_ray(o, d);
      o = '{65536, 0, 0}; d = '{299, 300, 0}; send_ray(o, d);
      send_random_rays(60);
    end
  endtask

  task automatic test_idle_phases();
    int pcts[4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{29, 29}};
    foreach (pcts[k]) begin
      send_idle_pct = pcts[k][0];
      recv_stall_pct = pcts[k][1];
      send_random_rays(150);
      if (k == 1) drain_pipe();  // sender holds until all results are back
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // sink: random backpressure, compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    box_hit_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = box_hit_t'(m_axis_tdata_o[OUT_FIELDS_W-1:0]);
        if (hits_pending.size() == 0) begin
          $error("result beat with no ray outstanding: %h", m_axis_tdata_o);
          failures++;
        end else begin
          want = hits_pending.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit exp %0b got %0b", want.hit, got.hit); failures++;
          end
          if (got.t_near !== want.t_near) begin
            $error("t_near exp %0d got %0d", want.t_near, got.t_near); failures++;
          end
          if (got.t_far !== want.t_far) begin
            $error("t_far exp %0d got %0d", want.t_far, got.t_far); failures++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: too long without any beat on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[ray_unit_box_slab_intersect] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_epsilon_sweep();
    test_idle_phases();
    send_random_rays(100);
    drain_pipe();
    if (failures == 0 && hits_pending.size() == 0) begin
      $display("[ray_unit_box_slab_intersect] OK");
    end else begin
      $display("[ray_unit_box_slab_intersect] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
